/* rtl/core/double_hash_set_insert_defines.svh */
// Assertion macros for the double-hash set insert block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DOUBLE_HASH_SET_INSERT_DEFINES_SVH
`define DOUBLE_HASH_SET_INSERT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DHSI_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("dhsi assertion failed");
// next-cycle implication
`define DHSI_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("dhsi assertion failed");
`else
`define DHSI_ASSERT_IMP(label, clk, rst_n, a, c)
`define DHSI_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/core/dhsi_pkg.sv */
// Shared types, constants and hash/convert functions of the double-hash set insert.
// No dependencies.
`timescale 1ns / 1ps
package dhsi_pkg;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam int MOD_BITS = 4;            // dividend bits retired per cycle
  localparam int MOD_CYCLES = 64 / MOD_BITS;
  localparam int MOD_CW = $clog2(MOD_CYCLES);

  // Fixed-point image of a double: 24 integer bits, 87 fraction bits, one jam bit.
  localparam int MAG_W = 111;
  localparam int FX_W = MAG_W + 2;
  localparam int DF_W = FX_W + 1;
  localparam logic [10:0] FIX_EXP0 = 11'd988;    // exponent whose lsb lands on bit 0
  localparam logic [10:0] FIX_BIG_EXP = 11'd1047; // magnitude 2^24 and up
  // Largest difference that still rounds below 1e-9, scaled by 2^88.
  localparam logic signed [DF_W-1:0] MATCH_LIM = DF_W'(114'h225C17D04DAD29 << 5);

  typedef struct packed {
    logic bad;              // inf or NaN
    logic big;              // finite, magnitude >= 2^24
    logic [FX_W-1:0] fx;    // two's complement fixed point
  } fixed_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic mod_step;
    logic seed;
    logic conv;
    logic decide;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic slot_empty;
    logic slot_match;
    logic probe_last;
  } dp_stat_t;

  function automatic logic [31:0] elf_hash(input logic [63:0] b);
    logic [31:0] h;
    logic [31:0] top;
    h = '0;
    for (int k = 0; k < 8; k++) begin
      h = (h << 4) + {24'd0, b[8*k +: 8]};
      top = h & 32'hF000_0000;
      if (top != 32'd0) begin
        h = h ^ (top >> 24);
        h = h ^ top;
      end
    end
    return h;
  endfunction

  function automatic logic [63:0] step_value(input logic [63:0] b);
    logic [10:0] ex;
    logic [52:0] sig;
    logic [63:0] t;
    ex = b[62:52];
    sig = {1'b1, b[51:0]};
    if (ex == 11'h7FF && b[51:0] != 52'd0) begin
      t = '0;
    end else if (b[63]) begin
      t = '0;
    end else if (ex >= 11'd1087) begin
      t = '1;
    end else if (ex < 11'd1023) begin
      t = '0;
    end else if (ex >= 11'd1075) begin
      t = {11'd0, sig} << (ex - 11'd1075);
    end else begin
      t = {11'd0, sig} >> (11'd1075 - ex);
    end
    return {1'b0, t[63:1]} + 64'd1;
  endfunction

  // Restoring remainder over MOD_BITS dividend bits, msb first.
  function automatic logic [7:0] mod_digits(input logic [7:0] rem,
                                            input logic [MOD_BITS-1:0] dig,
                                            input logic [7:0] size);
    logic [8:0] r9;
    logic [7:0] r;
    r = rem;
    for (int k = MOD_BITS - 1; k >= 0; k--) begin
      r9 = {r, dig[k]};
      if (r9 >= {1'b0, size}) r9 = r9 - {1'b0, size};
      r = r9[7:0];
    end
    return r;
  endfunction

  // Bits below the grid are jammed into the lsb; only values under 2^-35 lose bits.
  function automatic fixed_t to_fixed(input logic [63:0] b);
    logic [10:0] ex;
    logic [52:0] sig;
    logic [MAG_W-1:0] mag;
    logic sticky;
    logic [11:0] rs;
    logic [52:0] mask;
    logic [MAG_W:0] jam;
    fixed_t f;
    ex = b[62:52];
    sig = {1'b1, b[51:0]};
    mag = '0;
    sticky = 1'b0;
    rs = '0;
    mask = '0;
    if (ex == 11'd0) begin
      sticky = |b[51:0];
    end else if (ex >= FIX_EXP0) begin
      mag = {{(MAG_W-53){1'b0}}, sig} << (ex - FIX_EXP0);
    end else begin
      rs = {1'b0, FIX_EXP0} - {1'b0, ex};
      if (rs >= 12'd53) begin
        sticky = 1'b1;
      end else begin
        mag = MAG_W'(sig >> rs);
        mask = ~({53{1'b1}} << rs);
        sticky = |(sig & mask);
      end
    end
    jam = {mag, sticky};
    f.fx = b[63] ? (-{1'b0, jam}) : {1'b0, jam};
    f.bad = (ex == 11'h7FF);
    f.big = (ex >= FIX_BIG_EXP) && (ex != 11'h7FF);
    return f;
  endfunction

endpackage

/* rtl/core/dhsi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dhsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/dhsi_ctrl.sv */
// Controller FSM: clearing pass, remainder iterations, probe sequence, result strobe.
// Depends on dhsi_pkg and double_hash_set_insert_defines.svh.
`timescale 1ns / 1ps
`include "double_hash_set_insert_defines.svh"
module dhsi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output dhsi_pkg::dp_cmd_t  cmd,
  input  dhsi_pkg::dp_stat_t stat
);
  import dhsi_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_SEED  = 7'b0001000,
    S_RD    = 7'b0010000,
    S_CONV  = 7'b0100000,
    S_CMP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic finish;

  assign finish = stat.slot_empty || stat.slot_match || stat.probe_last;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = 1'b0;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.seed = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: state_nxt = S_CONV;
      S_CONV: begin
        cmd.conv = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.decide = 1'b1;
        if (finish) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `DHSI_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r)
  `DHSI_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid_r)
  `DHSI_ASSERT_NXT(a_insert_reports, clk, rst_n, (state_r == S_CMP) && stat.slot_empty,
                   out_valid_r && !busy)
  `DHSI_ASSERT_IMP(a_no_result_in_clear, clk, rst_n, state_r == S_CLEAR, !out_valid_nxt)
endmodule

/* rtl/core/dhsi_dp.sv */
// Datapath: size register, hashes, remainder units, slot RAMs, compare and counters.
// Depends on dhsi_pkg and dhsi_ram.
`timescale 1ns / 1ps
module dhsi_dp #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dhsi_pkg::dp_cmd_t  cmd,
  output dhsi_pkg::dp_stat_t stat,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic [63:0]        in_value_bits,
  output logic [1:0]         out_status,
  output logic [6:0]         out_slot_index,
  output logic [7:0]         out_probe_count,
  output logic [7:0]         out_element_total,
  output logic [31:0]        out_collision_total,
  output logic [31:0]        out_duplicate_total
);
  import dhsi_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [12:0] DEPTH_C = 13'(TABLE_DEPTH);

  logic [7:0] cfg_size_r;
  logic [7:0] size_r, size_eff;
  logic [63:0] vbits_r;
  fixed_t fv_r, fs_r;
  logic [63:0] hdiv_r, sdiv_r;
  logic [7:0] hrem_r, srem_r;
  logic [MOD_CW-1:0] mod_cnt_r;
  logic [7:0] idx_r, step_r, probes_r;
  logic [7:0] elem_r;
  logic [31:0] coll_r, dup_r;
  logic [IW-1:0] clr_cnt_r;

  logic used_q;
  logic [63:0] val_q;
  logic used_we, used_wd;
  logic [IW-1:0] used_wa;

  logic signed [DF_W-1:0] diff;
  logic close;
  logic [8:0] adv9;
  logic [7:0] idx_adv, probes_inc, elem_inc;
  logic [31:0] coll_inc, dup_inc;
  logic finish;

  always_comb begin
    if (cfg_size_r == 8'd0) size_eff = 8'd1;
    else if ({5'd0, cfg_size_r} > DEPTH_C) size_eff = DEPTH_C[7:0];
    else size_eff = cfg_size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_size_r <= 8'd127;
    else if (cfg_wr_en) cfg_size_r <= cfg_wr_data;
  end

  // used bits are swept clear after reset; values are written only on insert
  assign used_we = cmd.clr_step || (cmd.decide && !used_q);
  assign used_wa = cmd.clr_step ? clr_cnt_r : IW'(idx_r);
  assign used_wd = !cmd.clr_step;

  dhsi_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_used (
    .clk(clk), .we(used_we), .waddr(used_wa), .wdata(used_wd),
    .raddr(IW'(idx_r)), .rdata(used_q)
  );

  dhsi_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_value (
    .clk(clk), .we(cmd.decide && !used_q), .waddr(IW'(idx_r)), .wdata(vbits_r),
    .raddr(IW'(idx_r)), .rdata(val_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + IW'(1);
  end

  // compare against the stored value converted in the previous cycle
  assign diff = $signed({fs_r.fx[FX_W-1], fs_r.fx}) - $signed({fv_r.fx[FX_W-1], fv_r.fx});
  always_comb begin
    if (fs_r.bad || fv_r.bad) close = 1'b0;
    else if (fs_r.big || fv_r.big) close = (val_q == vbits_r);
    else close = (diff <= MATCH_LIM) && (diff >= -MATCH_LIM);
  end

  assign adv9 = {1'b0, idx_r} + {1'b0, step_r};
  assign idx_adv = (adv9 >= {1'b0, size_r}) ? 8'(adv9 - {1'b0, size_r}) : adv9[7:0];
  assign probes_inc = probes_r + 8'd1;
  assign elem_inc = (elem_r == 8'hFF) ? elem_r : elem_r + 8'd1;
  assign coll_inc = (coll_r == '1) ? coll_r : coll_r + 32'd1;
  assign dup_inc = (dup_r == '1) ? dup_r : dup_r + 32'd1;

  assign stat.clr_last = (clr_cnt_r == IW'(TABLE_DEPTH - 1));
  assign stat.mod_last = (mod_cnt_r == MOD_CW'(MOD_CYCLES - 1));
  assign stat.slot_empty = !used_q;
  assign stat.slot_match = used_q && close;
  assign stat.probe_last = (probes_inc == size_r);
  assign finish = !used_q || close || stat.probe_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size_r <= size_eff;
      vbits_r <= in_value_bits;
      fv_r <= to_fixed(in_value_bits);
      hdiv_r <= {32'd0, elf_hash(in_value_bits)};
      sdiv_r <= step_value(in_value_bits);
      hrem_r <= '0;
      srem_r <= '0;
      mod_cnt_r <= '0;
    end
    if (cmd.mod_step) begin
      hrem_r <= mod_digits(hrem_r, hdiv_r[63 -: MOD_BITS], size_r);
      srem_r <= mod_digits(srem_r, sdiv_r[63 -: MOD_BITS], size_r);
      hdiv_r <= hdiv_r << MOD_BITS;
      sdiv_r <= sdiv_r << MOD_BITS;
      mod_cnt_r <= mod_cnt_r + MOD_CW'(1);
    end
    if (cmd.seed) begin
      idx_r <= hrem_r;
      step_r <= srem_r;
      probes_r <= '0;
    end
    if (cmd.conv) fs_r <= to_fixed(val_q);
    if (cmd.decide) begin
      probes_r <= probes_inc;
      if (used_q && !close) idx_r <= idx_adv;
      if (finish) begin
        out_slot_index <= idx_r[6:0];
        out_probe_count <= probes_inc;
        if (!used_q) out_status <= ST_INSERTED;
        else if (close) out_status <= ST_DUPLICATE;
        else out_status <= ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r <= '0;
      coll_r <= '0;
      dup_r <= '0;
    end else if (cmd.decide) begin
      if (!used_q) elem_r <= elem_inc;
      else if (close) dup_r <= dup_inc;
      else coll_r <= coll_inc;
    end
  end

  assign out_element_total = elem_r;
  assign out_collision_total = coll_r;
  assign out_duplicate_total = dup_r;
endmodule

/* rtl/core/double_hash_set_insert.sv */
// Top level of the double-hash set insert: controller plus datapath.
// Depends on dhsi_pkg, dhsi_ctrl, dhsi_dp, dhsi_ram.
//
//   channel   ports                               handshake
//   input     in_value_bits                       start && !busy
//   result    out_status .. out_duplicate_total   out_valid, one cycle
//   config    cfg_wr_data                         cfg_wr_en
//
// An item runs through the remainder iterations (4 dividend bits a cycle), a seed
// step, and then for each of P probes (1..size) the slot RAM read, conversion and
// the wide compare.
// The result strobe is registered and rises in the cycle after the last probe's compare; busy drops at the same time.
// After reset the used bits are swept clear with busy high.
// Results cannot be stalled; they show for one cycle only.
`timescale 1ns / 1ps
module double_hash_set_insert #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value_bits,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [6:0]  out_slot_index,
  output logic [7:0]  out_probe_count,
  output logic [7:0]  out_element_total,
  output logic [31:0] out_collision_total,
  output logic [31:0] out_duplicate_total
);
  import dhsi_pkg::*;

  dp_cmd_t cmd;
  dp_stat_t stat;

  dhsi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .cmd(cmd), .stat(stat)
  );

  dhsi_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_value_bits(in_value_bits),
    .out_status(out_status), .out_slot_index(out_slot_index),
    .out_probe_count(out_probe_count), .out_element_total(out_element_total),
    .out_collision_total(out_collision_total),
    .out_duplicate_total(out_duplicate_total)
  );
endmodule

/* bench/double_hash_set_insert_test.sv */
// Testbench for double_hash_set_insert: random and directed double inserts over
// several table sizes, checked item by item against an internal set model.
// Depends on dhsi_pkg and the double_hash_set_insert RTL.
`timescale 1ns / 1ps
module double_hash_set_insert_test;
  import dhsi_pkg::*;

  localparam int DEPTH = 128;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct {
    status_t     status;
    logic [6:0]  slot;
    logic [7:0]  probes;
    logic [7:0]  elements;
    logic [31:0] collisions;
    logic [31:0] duplicates;
  } insert_result_t;

  class set_scoreboard;
    logic [7:0]     size_reg;
    bit             used[DEPTH];
    logic [63:0]    stored[DEPTH];
    logic [7:0]     elem_cnt;
    logic [31:0]    coll_cnt;
    logic [31:0]    dup_cnt;
    insert_result_t awaited[$];
    int             errors;

    function new();
      size_reg = 8'd127;
      foreach (used[i]) used[i] = 1'b0;
      elem_cnt = '0;
      coll_cnt = '0;
      dup_cnt = '0;
      errors = 0;
    endfunction

    static function logic [31:0] elf32(logic [63:0] b);
      logic [31:0] h;
      logic [31:0] hi;
      h = '0;
      for (int k = 0; k < 8; k++) begin
        h = (h << 4) + 32'(b[8*k +: 8]);
        hi = h & 32'hF000_0000;
        if (hi != 0) h = h ^ (hi >> 24) ^ hi;
      end
      return h;
    endfunction

    // truncation to u64 with saturation, then halved plus one
    static function logic [63:0] probe_stride(logic [63:0] b);
      logic [10:0] ex;
      logic [63:0] t;
      ex = b[62:52];
      if (b[63] || (ex == 11'h7FF && b[51:0] != 0)) t = '0;
      else if (ex >= 11'd1087) t = '1;
      else if (ex < 11'd1023) t = '0;
      else if (ex >= 11'd1075) t = {11'd0, 1'b1, b[51:0]} << (ex - 11'd1075);
      else t = {11'd0, 1'b1, b[51:0]} >> (11'd1075 - ex);
      return (t >> 1) + 64'd1;
    endfunction

    static function logic [31:0] inc_sat(logic [31:0] c);
      return (c == '1) ? c : c + 1;
    endfunction

    function void note_item(logic [63:0] b);
      int unsigned sz, idx, stride, last, probes;
      real v, d;
      insert_result_t r;
      sz = size_reg;
      if (sz == 0) sz = 1;
      if (sz > DEPTH) sz = DEPTH;
      v = $bitstoreal(b);
      idx = elf32(b) % sz;
      stride = probe_stride(b) % sz;
      last = idx;
      probes = 0;
      r.status = ST_FULL;
      for (int i = 0; i < sz; i++) begin
        last = idx;
        probes++;
        if (!used[idx]) begin
          used[idx] = 1'b1;
          stored[idx] = b;
          if (elem_cnt != 8'hFF) elem_cnt++;
          r.status = ST_INSERTED;
          break;
        end
        d = $bitstoreal(stored[idx]) - v;
        if (d < 0.0) d = -d;
        if (d < 1e-9) begin
          dup_cnt = inc_sat(dup_cnt);
          r.status = ST_DUPLICATE;
          break;
        end
        coll_cnt = inc_sat(coll_cnt);
        idx = (idx + stride) % sz;
      end
      if (probes > 255) probes = 255;
      r.slot = last[6:0];
      r.probes = probes[7:0];
      r.elements = elem_cnt;
      r.collisions = coll_cnt;
      r.duplicates = dup_cnt;
      awaited.push_back(r);
    endfunction

    function void mismatch(string what, longint unsigned e, longint unsigned a);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, e, a);
      errors++;
    endfunction

    function void check_result(insert_result_t a);
      insert_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, status %0d slot %0d", $time, a.status, a.slot);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (a.status !== e.status) mismatch("status", e.status, a.status);
      if (a.slot !== e.slot) mismatch("slot_index", e.slot, a.slot);
      if (a.probes !== e.probes) mismatch("probe_count", e.probes, a.probes);
      if (a.elements !== e.elements) mismatch("element_total", e.elements, a.elements);
      if (a.collisions !== e.collisions)
        mismatch("collision_total", e.collisions, a.collisions);
      if (a.duplicates !== e.duplicates)
        mismatch("duplicate_total", e.duplicates, a.duplicates);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_value_bits = '0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [6:0]  out_slot_index;
  logic [7:0]  out_probe_count;
  logic [7:0]  out_element_total;
  logic [31:0] out_collision_total;
  logic [31:0] out_duplicate_total;

  set_scoreboard sb = new();
  logic [63:0]   history[$];
  longint        cycles = 0;

  double_hash_set_insert #(.TABLE_DEPTH(DEPTH)) dut (
    .clk, .rst_n, .start, .busy, .in_value_bits, .cfg_wr_en, .cfg_wr_data,
    .out_valid, .out_status, .out_slot_index, .out_probe_count,
    .out_element_total, .out_collision_total, .out_duplicate_total
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    insert_result_t a;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("double_hash_set_insert_test failed");
      $finish;
    end
    if (rst_n && out_valid) begin
      a.status = status_t'(out_status);
      a.slot = out_slot_index;
      a.probes = out_probe_count;
      a.elements = out_element_total;
      a.collisions = out_collision_total;
      a.duplicates = out_duplicate_total;
      sb.check_result(a);
    end
  end

  // start stays high across back-to-back items
  task automatic send_item(logic [63:0] b);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value_bits <= b;
    do @(posedge clk); while (busy);
    sb.note_item(b);
    history.push_back(b);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.awaited.size() != 0 || busy);
  endtask

  task automatic set_size(logic [7:0] s);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.size_reg = s;
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] b;
    case ($urandom_range(0, 9))
      0: b = {$urandom, $urandom};
      1, 2: b = history.size() ? history[$urandom_range(0, history.size() - 1)]
                               : 64'h3FF0_0000_0000_0000;
      3: begin
        b = history.size() ? history[$urandom_range(0, history.size() - 1)] : '0;
        b = b ^ 64'($urandom_range(1, 15));
      end
      4: b = $realtobits(real'($urandom_range(0, 5000)));
      5: b = $realtobits(-real'($urandom_range(0, 5000)) / 3.0);
      6: b = $realtobits(real'($urandom_range(0, 100000)) * 1e-12);
      7: b = {1'b0, 11'(1080 + $urandom_range(0, 20)), $urandom, 20'($urandom)};
      8: b = {1'($urandom), 11'h7FF, 20'($urandom_range(0, 1)), 32'($urandom_range(0, 1))};
      default: b = {1'($urandom), 11'd0, 20'($urandom), $urandom};
    endcase
    return b;
  endfunction

  initial begin
    logic [63:0] directed[$];
    logic [7:0]  sizes[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    directed = '{64'h0, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                 $realtobits(1.0 + 1e-12), 64'h3FF0_0000_0000_0000,
                 64'h43E0_0000_0000_0000, 64'h43F0_0000_0000_0000,
                 64'h43EF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
                 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                 64'h7FF8_0000_0000_0000, 64'h7FF8_0000_0000_0000,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
                 64'h000F_FFFF_FFFF_FFFF, 64'hBFF8_0000_0000_0000,
                 64'h3FE0_0000_0000_0000, 64'h4000_0000_0000_0000};
    foreach (directed[i]) send_item(directed[i]);

    // sizes exercised in turn; entries persist across resizes
    sizes = '{8'd1, 8'd2, 8'd0, 8'd7, 8'd13, 8'd128, 8'd200, 8'd31, 8'd127};
    foreach (sizes[p]) begin
      set_size(sizes[p]);
      repeat (48) send_item(pick_value());
    end

    start <= 1'b0;
    while (sb.awaited.size() != 0 || busy) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("double_hash_set_insert_test passed");
    end else begin
      $display("double_hash_set_insert_test failed");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/dhsi_pkg.sv
rtl/core/dhsi_ram.sv
rtl/core/dhsi_ctrl.sv
rtl/core/dhsi_dp.sv
rtl/core/double_hash_set_insert.sv
bench/double_hash_set_insert_test.sv
